FILE: rtl/dts_pkg.sv
// Package for the deadline timer scheduler: sizes, field offsets of the stream
// payloads, and the command, slot status and sequencer state types.
// No dependencies; used by deadline_timer_scheduler_unit.
`default_nettype none

package dts_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int TIME_BITS  = 48;
   localparam int ORDER_W    = 32;
   localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
   localparam int ENTRY_W    = ORDER_W + TIME_BITS;

   // Fixed field widths of the stream payloads.
   localparam int FUNC_W  = 3;
   localparam int ID_W    = 4;
   localparam int FIELD_TIME_W = 48;

   // req_tdata layout, lowest bit first.
   localparam int REQ_ID_LSB      = 0;
   localparam int REQ_WHEN_LSB    = REQ_ID_LSB + ID_W;
   localparam int REQ_EARLIER_BIT = REQ_WHEN_LSB + FIELD_TIME_W;
   localparam int REQ_NOW_LSB     = REQ_EARLIER_BIT + 1;
   localparam int REQ_USED_W      = REQ_NOW_LSB + FIELD_TIME_W;
   localparam int REQ_TDATA_W     = ((REQ_USED_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W     = FUNC_W;

   // rsp_tdata layout, lowest bit first.
   localparam int RSP_ACC_BIT = ID_W;
   localparam int RSP_USED_W  = ID_W + 1;
   localparam int RSP_TDATA_W = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK     = 3'd0,
      FUNC_SCHEDULE = 3'd1,
      FUNC_STOP     = 3'd2,
      FUNC_DELETE   = 3'd3,
      FUNC_RECREATE = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      SLOT_IDLE    = 2'd0,
      SLOT_ARMED   = 2'd1,
      SLOT_DELETED = 2'd2
   } slot_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMD,
      ST_SCAN,
      ST_DECIDE
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/deadline_timer_scheduler_unit.sv
// Deadline timer scheduler top level: slot status registers, a deadline/stamp
// memory and one shared compare unit stepped by a small sequencer.
// Depends on dts_pkg.
//
// Usage: commands and ticks enter on the req_ stream; every transaction
// yields one or more transactions on the rsp_ stream, the final one with
// rsp_tlast set. A schedule, stop, delete or re-create reads the slot's entry
// at the accepting edge and loads its single result into the output register
// once that register is free. A tick scans all NUM_TIMERS slots through the
// shared deadline compare, one slot per cycle, and then decides in ST_DECIDE;
// a tick that fires k slots runs k + 1 scans. A fired slot is reported once
// the following scan has shown whether it was the last.
// req_tready is high only while the sequencer is idle; one transaction is in
// work at a time. Results sit in an output register, so the block returns to
// idle while the final result still waits for rsp_tready. When the receiver
// stalls, the sequencer holds at the point where it needs the output register.
// Reset returns every slot to unscheduled and clears the stamp counter; the
// deadline memory is not cleared, as an entry is read only after a schedule.
`default_nettype none

module deadline_timer_scheduler_unit
   import dts_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   // timer_id[3:0], when_time[51:4], earlier_only[52], now_time[100:53], zero fill
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // func[2:0]
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // fired_timer[3:0], accepted[4], zero fill
   output      logic [RSP_TDATA_W-1:0] rsp_tdata,
   // fired[0]
   output      logic [0:0]             rsp_tuser,
   output      logic                   rsp_tlast
);

   state_type state_ff, state_in;

   logic [FUNC_W-1:0]    func_ff;
   logic [ID_W-1:0]      id_ff;
   logic [TIME_BITS-1:0] when_ff;
   logic                 earlier_ff;
   logic [TIME_BITS-1:0] now_ff;

   slot_status_type status_ff [NUM_TIMERS];
   logic            status_we;
   logic [IDX_W-1:0] status_idx;
   slot_status_type status_val;

   logic [ENTRY_W-1:0] slot_mem [NUM_TIMERS];
   logic               mem_we;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               rd_vld_ff, rd_vld_in;

   logic [CNT_W-1:0]   scan_cnt_ff, scan_cnt_in;

   logic                 best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [TIME_BITS-1:0] best_dl_ff;
   logic [ORDER_W-1:0]   best_ord_ff;

   logic             pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;

   logic [ORDER_W-1:0] order_cnt_ff, order_cnt_in;

   logic            rsp_vld_ff;
   logic            rsp_fired_ff, rsp_fired_in;
   logic [ID_W-1:0] rsp_timer_ff, rsp_timer_in;
   logic            rsp_acc_ff, rsp_acc_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            load_out;
   logic            out_free;

   logic                 req_accept;
   logic [FUNC_W-1:0]    req_func;
   logic [ID_W-1:0]      req_id;
   logic                 req_id_ok;
   logic [TIME_BITS-1:0] rd_dl;
   logic [ORDER_W-1:0]   rd_ord;
   logic                 cand;
   logic                 better;
   logic                 cmd_id_ok;
   logic [IDX_W-1:0]     cmd_slot;
   slot_status_type      cmd_cur;

   assign req_func   = req_tuser[FUNC_W-1:0];
   assign req_id     = req_tdata[REQ_ID_LSB +: ID_W];
   assign req_id_ok  = int'(req_id) < NUM_TIMERS;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   assign rd_dl  = rd_data_ff[TIME_BITS-1:0];
   assign rd_ord = rd_data_ff[ENTRY_W-1:TIME_BITS];

   assign cmd_id_ok = int'(id_ff) < NUM_TIMERS;
   assign cmd_slot  = IDX_W'(id_ff);
   assign cmd_cur   = cmd_id_ok ? status_ff[cmd_slot] : SLOT_IDLE;

   // Shared compare unit: is the slot just read due, and does it beat the
   // best one found so far in this scan (earlier deadline, then lower stamp)?
   assign cand   = rd_vld_ff && (status_ff[rd_idx_ff] == SLOT_ARMED) && (rd_dl <= now_ff);
   assign better = !best_vld_ff || (rd_dl < best_dl_ff) ||
                   ((rd_dl == best_dl_ff) && (rd_ord < best_ord_ff));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (func_type'(req_func) == FUNC_TICK) ? ST_SCAN : ST_CMD;
            end
         end
         ST_CMD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (int'(scan_cnt_ff) == NUM_TIMERS) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (best_vld_ff) begin
               if (!pend_vld_ff || out_free) begin
                  state_in = ST_SCAN;
               end
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      rd_addr      = scan_cnt_ff[IDX_W-1:0];
      rd_vld_in    = 1'b0;
      scan_cnt_in  = scan_cnt_ff;
      best_vld_in  = best_vld_ff;
      pend_vld_in  = pend_vld_ff;
      pend_idx_in  = pend_idx_ff;
      order_cnt_in = order_cnt_ff;
      status_we    = 1'b0;
      status_idx   = cmd_slot;
      status_val   = SLOT_IDLE;
      mem_we       = 1'b0;
      load_out     = 1'b0;
      rsp_fired_in = 1'b0;
      rsp_timer_in = '0;
      rsp_acc_in   = 1'b0;
      rsp_last_in  = 1'b1;

      if (cand && better) begin
         best_vld_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr     = req_id_ok ? IDX_W'(req_id) : '0;
            scan_cnt_in = '0;
            best_vld_in = 1'b0;
            pend_vld_in = 1'b0;
         end
         ST_CMD: begin
            // Keep the addressed entry on the read port while the result waits.
            rd_addr = cmd_slot;
            if (out_free) begin
               load_out = 1'b1;
               if (cmd_id_ok) begin
                  unique case (func_type'(func_ff))
                     FUNC_SCHEDULE: begin
                        if ((cmd_cur != SLOT_DELETED) &&
                            !(earlier_ff && (cmd_cur == SLOT_ARMED) && (when_ff >= rd_dl))) begin
                           rsp_acc_in   = 1'b1;
                           mem_we       = 1'b1;
                           status_we    = 1'b1;
                           status_val   = SLOT_ARMED;
                           order_cnt_in = order_cnt_ff + 1'b1;
                        end
                     end
                     FUNC_STOP: begin
                        rsp_acc_in = 1'b1;
                        if (cmd_cur == SLOT_ARMED) begin
                           status_we = 1'b1;
                        end
                     end
                     FUNC_DELETE: begin
                        rsp_acc_in = 1'b1;
                        status_we  = 1'b1;
                        status_val = SLOT_DELETED;
                     end
                     FUNC_RECREATE: begin
                        if (cmd_cur == SLOT_DELETED) begin
                           rsp_acc_in = 1'b1;
                           status_we  = 1'b1;
                        end
                     end
                     default: begin
                        rsp_acc_in = 1'b0;
                     end
                  endcase
               end
            end
         end
         ST_SCAN: begin
            if (int'(scan_cnt_ff) < NUM_TIMERS) begin
               rd_vld_in   = 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            if (best_vld_ff) begin
               // A further due slot exists, so the held one was not the last.
               if (!pend_vld_ff || out_free) begin
                  load_out     = pend_vld_ff;
                  rsp_fired_in = 1'b1;
                  rsp_timer_in = ID_W'(pend_idx_ff);
                  rsp_acc_in   = 1'b1;
                  rsp_last_in  = 1'b0;
                  pend_vld_in  = 1'b1;
                  pend_idx_in  = best_idx_ff;
                  status_we    = 1'b1;
                  status_idx   = best_idx_ff;
                  status_val   = SLOT_IDLE;
                  scan_cnt_in  = '0;
                  best_vld_in  = 1'b0;
               end
            end else if (out_free) begin
               load_out     = 1'b1;
               rsp_fired_in = pend_vld_ff;
               rsp_timer_in = pend_vld_ff ? ID_W'(pend_idx_ff) : '0;
               rsp_acc_in   = 1'b1;
               rsp_last_in  = 1'b1;
            end
         end
         default: begin
            rd_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         scan_cnt_ff  <= '0;
         best_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         order_cnt_ff <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         scan_cnt_ff  <= scan_cnt_in;
         best_vld_ff  <= best_vld_in;
         pend_vld_ff  <= pend_vld_in;
         order_cnt_ff <= order_cnt_in;
         if (load_out) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            status_ff[i] <= SLOT_IDLE;
         end
      end else if (status_we) begin
         status_ff[status_idx] <= status_val;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff    <= req_func;
         id_ff      <= req_id;
         when_ff    <= TIME_BITS'(req_tdata[REQ_WHEN_LSB +: FIELD_TIME_W]);
         earlier_ff <= req_tdata[REQ_EARLIER_BIT];
         now_ff     <= TIME_BITS'(req_tdata[REQ_NOW_LSB +: FIELD_TIME_W]);
      end
      rd_idx_ff   <= rd_addr;
      pend_idx_ff <= pend_idx_in;
      if (cand && better) begin
         best_idx_ff <= rd_idx_ff;
         best_dl_ff  <= rd_dl;
         best_ord_ff <= rd_ord;
      end
      if (load_out) begin
         rsp_fired_ff <= rsp_fired_in;
         rsp_timer_ff <= rsp_timer_in;
         rsp_acc_ff   <= rsp_acc_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // Deadline and stamp memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[cmd_slot] <= {order_cnt_ff, when_ff};
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = RSP_TDATA_W'({rsp_acc_ff, rsp_timer_ff});
   assign rsp_tuser[0] = rsp_fired_ff;
   assign rsp_tlast    = rsp_last_ff;

   // A result that reports no fired slot ends its transaction run.
   a_nofire_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tlast && (rsp_tdata[ID_W-1:0] == '0)))
      else $error("non-fire result without last or with a slot number");

   // The scan counter never runs past one beyond the last slot.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      int'(scan_cnt_ff) <= NUM_TIMERS)
      else $error("scan counter out of range");

   // The best candidate of a running scan is still armed.
   a_best_armed: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN || state_ff == ST_DECIDE) && best_vld_ff)
         |-> (status_ff[best_idx_ff] == SLOT_ARMED))
      else $error("best candidate is not armed");

   // The stamp counter moves only on an accepted schedule command.
   a_order_step: assert property (@(posedge clock) disable iff (reset)
      (order_cnt_ff != $past(order_cnt_ff)) |-> ($past(state_ff) == ST_CMD && $past(mem_we)))
      else $error("stamp counter changed outside a schedule");

endmodule

`default_nettype wire

FILE: tb/deadline_timer_scheduler_checker.sv
// Checker for the deadline timer scheduler: watches both streams, predicts the
// results of every accepted request and compares them with the returned ones.
// Depends on dts_pkg; instantiated beside the block by the testbench top.
`default_nettype none

module deadline_timer_scheduler_checker
   import dts_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   // timer_id, when_time, earlier_only, now_time, zero fill
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // func
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // fired_timer, accepted, zero fill
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   // fired
   input  wire logic [0:0]             rsp_tuser,
   input  wire logic                   rsp_tlast,
   output int unsigned                 mismatch_count,
   output int unsigned                 awaiting,
   output int unsigned                 fired_total,
   output int unsigned                 tick_total
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic            fired;
      logic [ID_W-1:0] timer;
      logic            accepted;
      logic            last;
   } timer_event_type;

   timer_event_type expected_events[$];

   slot_status_type      slot_state [NUM_TIMERS];
   logic [TIME_BITS-1:0] slot_when  [NUM_TIMERS];
   logic [ORDER_W-1:0]   slot_stamp [NUM_TIMERS];
   logic [ORDER_W-1:0]   stamp_next;

   // Fires every armed slot that is due, earliest deadline first and the
   // older stamp first on equal deadlines.
   task automatic predict_tick(input logic [TIME_BITS-1:0] now_t);
      int best;
      int fired_n;
      timer_event_type ev;
      fired_n = 0;
      tick_total++;
      do begin
         best = -1;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            if (slot_state[i] == SLOT_ARMED && slot_when[i] <= now_t) begin
               if (best < 0 || slot_when[i] < slot_when[best] ||
                   (slot_when[i] == slot_when[best] && slot_stamp[i] < slot_stamp[best]))
                  best = i;
            end
         end
         if (best >= 0) begin
            slot_state[best] = SLOT_IDLE;
            ev = '{fired: 1'b1, timer: best[ID_W-1:0], accepted: 1'b1, last: 1'b0};
            expected_events.push_back(ev);
            fired_n++;
            fired_total++;
         end
      end while (best >= 0 && fired_n < NUM_TIMERS);
      if (fired_n == 0) begin
         ev = '{fired: 1'b0, timer: '0, accepted: 1'b1, last: 1'b1};
         expected_events.push_back(ev);
      end else begin
         expected_events[$].last = 1'b1;
      end
   endtask

   task automatic predict_transaction(input logic [FUNC_W-1:0]    func,
                                      input logic [ID_W-1:0]      id,
                                      input logic [TIME_BITS-1:0] when_t,
                                      input logic                 earlier,
                                      input logic [TIME_BITS-1:0] now_t);
      logic done;
      timer_event_type ev;
      done = 1'b0;
      if (func == FUNC_TICK) begin
         predict_tick(now_t);
      end else begin
         if (id < NUM_TIMERS) begin
            case (func)
               FUNC_SCHEDULE: begin
                  if (slot_state[id] != SLOT_DELETED &&
                      !(earlier && slot_state[id] == SLOT_ARMED && when_t >= slot_when[id])) begin
                     slot_state[id] = SLOT_ARMED;
                     slot_when[id]  = when_t;
                     slot_stamp[id] = stamp_next;
                     stamp_next     = stamp_next + 1'b1;
                     done = 1'b1;
                  end
               end
               FUNC_STOP: begin
                  if (slot_state[id] == SLOT_ARMED)
                     slot_state[id] = SLOT_IDLE;
                  done = 1'b1;
               end
               FUNC_DELETE: begin
                  slot_state[id] = SLOT_DELETED;
                  done = 1'b1;
               end
               FUNC_RECREATE: begin
                  if (slot_state[id] == SLOT_DELETED) begin
                     slot_state[id] = SLOT_IDLE;
                     done = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ev = '{fired: 1'b0, timer: '0, accepted: done, last: 1'b1};
         expected_events.push_back(ev);
      end
   endtask

   always @(posedge clock) begin : monitor
      timer_event_type seen;
      timer_event_type want;
      if (reset) begin
         expected_events.delete();
         stamp_next = '0;
         for (int i = 0; i < NUM_TIMERS; i++)
            slot_state[i] = SLOT_IDLE;
         awaiting <= 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_transaction(req_tuser,
                                req_tdata[REQ_ID_LSB +: ID_W],
                                req_tdata[REQ_WHEN_LSB +: TIME_BITS],
                                req_tdata[REQ_EARLIER_BIT],
                                req_tdata[REQ_NOW_LSB +: TIME_BITS]);
         if (rsp_tvalid && rsp_tready) begin
            seen = '{fired: rsp_tuser[0], timer: rsp_tdata[ID_W-1:0],
                     accepted: rsp_tdata[RSP_ACC_BIT], last: rsp_tlast};
            if (expected_events.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 20)
                  $display({"%0t ns: unexpected result, expected none, ",
                            "got fired=%0b timer=%0d accepted=%0b last=%0b"},
                           $time, seen.fired, seen.timer, seen.accepted, seen.last);
            end else begin
               want = expected_events.pop_front();
               if (seen != want) begin
                  mismatch_count++;
                  if (mismatch_count <= 20)
                     $display({"%0t ns: result mismatch, ",
                               "expected fired=%0b timer=%0d accepted=%0b last=%0b, ",
                               "got fired=%0b timer=%0d accepted=%0b last=%0b"},
                              $time, want.fired, want.timer, want.accepted, want.last,
                              seen.fired, seen.timer, seen.accepted, seen.last);
               end
            end
         end
         // Updated with a nonblocking assignment so that the top always reads
         // the count as it stood after the previous edge.
         awaiting <= expected_events.size();
      end
   end

endmodule

`default_nettype wire

FILE: tb/deadline_timer_scheduler_unit_test.sv
// Testbench top for deadline_timer_scheduler_unit: clock, reset, directed and
// random request stimulus, a randomly stalling receiver and the verdict.
// Depends on dts_pkg and deadline_timer_scheduler_checker.
`default_nettype none

module deadline_timer_scheduler_unit_test;

   import dts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FUNC_CODES   = 1 << FUNC_W;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 2 * (NUM_TIMERS + 2) + 16;
   localparam int RANDOM_ITEMS = 220;
   localparam int CALM_FROM    = RANDOM_ITEMS - 40;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tready = 1'b0;
   wire logic              req_tready;
   wire logic              rsp_tvalid;
   wire logic [RSP_TDATA_W-1:0] rsp_tdata;
   wire logic [0:0]        rsp_tuser;
   wire logic              rsp_tlast;

   int unsigned mismatch_count;
   int unsigned awaiting;
   int unsigned fired_total;
   int unsigned tick_total;

   int unsigned          items_sent = 0;
   logic                 calm = 1'b0;
   logic                 sender_gaps = 1'b1;
   logic [TIME_BITS-1:0] cur_time = '0;

   deadline_timer_scheduler_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   deadline_timer_scheduler_checker timer_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .awaiting       (awaiting),
      .fired_total    (fired_total),
      .tick_total     (tick_total)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [TIME_BITS-1:0] random_time();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[TIME_BITS-1:0];
   endfunction

   // Offers one transaction and returns at the edge where it is taken.
   task automatic issue_request(input logic [FUNC_W-1:0]    func,
                                input logic [ID_W-1:0]      id,
                                input logic [TIME_BITS-1:0] when_t,
                                input logic                 earlier,
                                input logic [TIME_BITS-1:0] now_t);
      logic [REQ_TDATA_W-1:0] word;
      word = '0;
      word[REQ_ID_LSB +: ID_W]        = id;
      word[REQ_WHEN_LSB +: TIME_BITS] = when_t;
      word[REQ_EARLIER_BIT]           = earlier;
      word[REQ_NOW_LSB +: TIME_BITS]  = now_t;
      if (items_sent % 16 == 0)
         sender_gaps = ($urandom_range(0, 2) != 0);
      if (!calm && sender_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tuser  <= func;
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic schedule_slot(input logic [ID_W-1:0] id, input logic [TIME_BITS-1:0] when_t,
                                input logic earlier);
      issue_request(FUNC_SCHEDULE, id, when_t, earlier, random_time());
   endtask

   task automatic slot_command(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] id);
      issue_request(func, id, random_time(), 1'($urandom), random_time());
   endtask

   task automatic tick_at(input logic [TIME_BITS-1:0] now_t);
      issue_request(FUNC_TICK, 4'($urandom), random_time(), 1'($urandom), now_t);
   endtask

   // Receiver: random ready and stall bursts, one long hold-off early on,
   // and steady acceptance once the run has gone calm.
   initial begin
      int bursts;
      bursts = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (calm) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            bursts++;
            if (bursts == 30) begin
               rsp_tready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
            end else if ($urandom_range(0, 2) == 0) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(1, 16)) @(posedge clock);
            end else begin
               rsp_tready <= 1'b1;
               repeat ($urandom_range(1, 16)) @(posedge clock);
            end
         end
      end
   end

   initial begin
      int pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extremes of the times, refusals, ties and every command.
      tick_at('0);
      schedule_slot(4'd0, '0, 1'b0);
      schedule_slot(4'd15, TIME_MAX, 1'b0);
      schedule_slot(4'd1, 48'd100, 1'b0);
      schedule_slot(4'd2, 48'd100, 1'b0);
      schedule_slot(4'd1, 48'd200, 1'b1);     // later, so refused
      schedule_slot(4'd1, 48'd100, 1'b1);     // equal, so refused
      schedule_slot(4'd3, 48'd50, 1'b1);      // not armed, so taken
      schedule_slot(4'd2, 48'd99, 1'b1);      // earlier, so taken
      tick_at(48'd100);
      slot_command(FUNC_STOP, 4'd5);
      slot_command(FUNC_DELETE, 4'd6);
      schedule_slot(4'd6, 48'd7, 1'b0);       // deleted slot refuses
      slot_command(FUNC_RECREATE, 4'd7);
      slot_command(FUNC_RECREATE, 4'd6);
      schedule_slot(4'd6, 48'd5, 1'b0);
      slot_command(FUNC_STOP, 4'd6);
      tick_at(48'd10);
      slot_command(FUNC_DELETE, 4'd15);
      tick_at(TIME_MAX);
      slot_command(FUNC_RECREATE, 4'd15);
      for (int f = FUNC_RECREATE + 1; f < FUNC_CODES; f++)
         slot_command(f[FUNC_W-1:0], 4'($urandom));

      cur_time = 48'd1000;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == CALM_FROM) begin
            calm = 1'b1;
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         if (n == 60 || n == 150) begin
            // Arm every slot, half of them on one shared deadline, then fire all.
            for (int i = 0; i < NUM_TIMERS; i++) begin
               slot_command(FUNC_RECREATE, i[ID_W-1:0]);
               schedule_slot(i[ID_W-1:0], cur_time + ((i % 2) ? 0 : $urandom_range(0, 8)),
                             1'b0);
            end
            tick_at(cur_time + 48'd8);
            cur_time = cur_time + 48'd8;
         end
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            schedule_slot(4'($urandom),
                          ($urandom_range(0, 9) == 0) ? random_time()
                                                      : cur_time + $urandom_range(0, 64),
                          1'($urandom));
         end else if (pick < 55) begin
            if ($urandom_range(0, 9) == 0) begin
               tick_at(random_time());
            end else begin
               tick_at(cur_time);
               cur_time = cur_time + $urandom_range(0, 48);
            end
         end else if (pick < 65) begin
            slot_command(FUNC_STOP, 4'($urandom));
         end else if (pick < 73) begin
            slot_command(FUNC_DELETE, 4'($urandom));
         end else if (pick < 83) begin
            slot_command(FUNC_RECREATE, 4'($urandom));
         end else if (pick < 88) begin
            slot_command(FUNC_W'($urandom_range(FUNC_RECREATE + 1, FUNC_CODES - 1)),
                         4'($urandom));
         end else begin
            schedule_slot(4'($urandom), cur_time + 48'd8, 1'($urandom));
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d transactions: %0d ticks firing %0d timers in total,",
               items_sent, tick_total, fired_total);
      $display("with receiver stalls, one long hold-off and sender gaps.");
      if (mismatch_count == 0 && awaiting == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
